// ===== src/sed_pkg.sv =====
// Shared types, constants and helper functions of the string escape decoder.
package sed_pkg;

  // Width of the input position and output length counters
  localparam int unsigned POS_W     = 16;
  // Width of the position and length fields of a result word
  localparam int unsigned FIELD_W   = 16;
  // Depth of the queue between front and back
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QAW       = $clog2(QDEPTH);

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // End status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TRAIL_BS  = 3'd1;
  localparam logic [2:0] ST_NO_HEX    = 3'd2;
  localparam logic [2:0] ST_HEX_NUL   = 3'd3;
  localparam logic [2:0] ST_BAD_ESC   = 3'd4;

  // Characters with a meaning of their own
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_X      = 8'h78;

  // One queue entry: everything that one input word produces
  typedef struct packed {
    logic [1:0]         n_data;
    logic [7:0]         byte0;
    logic [7:0]         byte1;
    logic               has_end;
    logic [2:0]         status;
    logic [FIELD_W-1:0] error_pos;
    logic [FIELD_W-1:0] out_length;
  } sed_entry_t;

  // Saturating increment of a position counter
  function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
    return (v == POS_MAX) ? v : v + POS_W'(1);
  endfunction

  // Step a position back, stopping at zero
  function automatic logic [POS_W-1:0] pos_back(input logic [POS_W-1:0] p,
                                                input logic [1:0] k);
    logic [POS_W-1:0] kk;
    kk = POS_W'(k);
    return (p >= kk) ? p - kk : '0;
  endfunction

  // Hex digit value; bit 4 flags a valid digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // Single-character escapes; bit 8 flags a known escape
  function automatic logic [8:0] esc_map(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      8'h6e:   r = {1'b1, 8'd10};  // n
      8'h74:   r = {1'b1, 8'd9};   // t
      8'h72:   r = {1'b1, 8'd13};  // r
      8'h30:   r = {1'b1, 8'd0};   // 0
      8'h5c:   r = {1'b1, 8'd92};  // backslash
      8'h22:   r = {1'b1, 8'd34};  // double quote
      8'h27:   r = {1'b1, 8'd39};  // single quote
      8'h62:   r = {1'b1, 8'd8};   // b
      8'h66:   r = {1'b1, 8'd12};  // f
      8'h76:   r = {1'b1, 8'd11};  // v
      8'h61:   r = {1'b1, 8'd7};   // a
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/sed_in_if.sv =====
// Input channel: one raw character word with a last mark.
interface sed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last;

  modport source (output valid, output in_byte, output last, input ready);
  modport sink   (input valid, input in_byte, input last, output ready);
endinterface

// ===== src/sed_out_if.sv =====
// Output channel: decoded byte or end-of-string status word.
interface sed_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        is_end;
  logic [2:0]  status;
  logic [15:0] error_pos;
  logic [15:0] out_length;
  logic        run_last;

  modport source (output valid, output out_byte, output is_end, output status,
                  output error_pos, output out_length, output run_last,
                  input ready);
  modport sink   (input valid, input out_byte, input is_end, input status,
                  input error_pos, input out_length, input run_last,
                  output ready);
endinterface

// ===== src/string_escape_decoder_core.sv =====
// Top level of the string escape decoder: front, result queue and back.
// An accepted word's results are written into the result queue and reach the output from there.
// Throughput: one input word per cycle while each word gives at most one result
// and the output is not stalled; a word giving two or three results holds the output
// until all are taken. The four-entry queue between the state machine and the output sets this.
// Reset (rst_ni low, asynchronous) clears escape state, counters and the queue.
module string_escape_decoder_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  sed_in_if.sink    in_i,
  sed_out_if.source out_o
);
  import sed_pkg::*;

  logic       accept;
  logic       push;
  logic       full;
  logic       pop;
  logic       empty;
  sed_entry_t entry;
  sed_entry_t head;

  assign in_i.ready = !full;
  assign accept     = in_i.valid && in_i.ready;

  sed_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_i.in_byte),
    .last_i    (in_i.last),
    .push_o    (push),
    .entry_o   (entry)
  );

  sed_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  sed_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ===== src/sed_front.sv =====
// Front end: escape state machine, counters and per-word result bundle.
module sed_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          in_byte_i,
  input  logic                last_i,
  output logic                push_o,
  output sed_pkg::sed_entry_t entry_o
);
  import sed_pkg::*;

  localparam logic [1:0] M_NORMAL = 2'd0;
  localparam logic [1:0] M_ESC    = 2'd1;
  localparam logic [1:0] M_HEX1   = 2'd2;
  localparam logic [1:0] M_HEX2   = 2'd3;

  logic [1:0]       mode_q, mode_d;
  logic [3:0]       hex_q, hex_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] cnt_q, cnt_d;
  logic [2:0]       err_q, err_d;
  logic [POS_W-1:0] epos_q, epos_d;

  // Decode one word against the current state
  always_comb begin
    logic [1:0]       mode_v;
    logic [POS_W-1:0] cnt_v;
    logic [2:0]       err_v;
    logic [POS_W-1:0] epos_v;
    logic [1:0]       n_v;
    logic [7:0]       b_v [2];
    logic             consumed;
    logic [4:0]       h;
    logic [8:0]       e;
    logic [7:0]       val;

    mode_v   = mode_q;
    cnt_v    = cnt_q;
    err_v    = err_q;
    epos_v   = epos_q;
    n_v      = '0;
    b_v[0]   = '0;
    b_v[1]   = '0;
    consumed = 1'b0;
    h        = hex_value(in_byte_i);
    e        = esc_map(in_byte_i);
    val      = '0;

    if (err_q == ST_OK) begin
      // Second hex digit, or the byte that ends a one-digit escape
      if (mode_v == M_HEX2) begin
        mode_v = M_NORMAL;
        if (h[4]) begin
          val      = {hex_q, h[3:0]};
          consumed = 1'b1;
          if (val == 8'd0) begin
            err_v  = ST_HEX_NUL;
            epos_v = pos_back(pos_q, 2'd1);
          end else begin
            b_v[n_v[0]] = val;
            n_v         = n_v + 2'd1;
            cnt_v       = sat_inc(cnt_v);
          end
        end else begin
          val = {4'd0, hex_q};
          if (val == 8'd0) begin
            err_v  = ST_HEX_NUL;
            epos_v = pos_back(pos_q, 2'd2);
          end else begin
            b_v[n_v[0]] = val;
            n_v         = n_v + 2'd1;
            cnt_v       = sat_inc(cnt_v);
          end
        end
      end
      // Ordinary decode of the byte
      if (!consumed && err_v == ST_OK) begin
        case (mode_v)
          M_NORMAL: begin
            if (in_byte_i == CH_BSLASH) begin
              mode_v = M_ESC;
            end else begin
              b_v[n_v[0]] = in_byte_i;
              n_v         = n_v + 2'd1;
              cnt_v       = sat_inc(cnt_v);
            end
          end
          M_ESC: begin
            mode_v = M_NORMAL;
            if (e[8]) begin
              b_v[n_v[0]] = e[7:0];
              n_v         = n_v + 2'd1;
              cnt_v       = sat_inc(cnt_v);
            end else if (in_byte_i == CH_X) begin
              mode_v = M_HEX1;
            end else begin
              err_v  = ST_BAD_ESC;
              epos_v = pos_back(pos_q, 2'd1);
            end
          end
          default: begin
            // first hex digit expected
            if (h[4]) begin
              mode_v = M_HEX2;
            end else begin
              mode_v = M_NORMAL;
              err_v  = ST_NO_HEX;
              epos_v = pos_back(pos_q, 2'd2);
            end
          end
        endcase
      end
    end

    // Close any pending escape at the end of the string
    if (last_i && err_v == ST_OK) begin
      case (mode_v)
        M_ESC: begin
          err_v  = ST_TRAIL_BS;
          epos_v = pos_q;
        end
        M_HEX1: begin
          err_v  = ST_NO_HEX;
          epos_v = pos_back(pos_q, 2'd1);
        end
        M_HEX2: begin
          // digit held from this word or an earlier one
          val = (mode_q == M_HEX2) ? {4'd0, hex_q} : {4'd0, h[3:0]};
          if (mode_q != M_HEX2 && val == 8'd0) begin
            err_v  = ST_HEX_NUL;
            epos_v = pos_back(pos_q, 2'd1);
          end else if (mode_q == M_HEX2 && val == 8'd0) begin
            err_v  = ST_HEX_NUL;
            epos_v = pos_back(pos_q, 2'd1);
          end else begin
            b_v[n_v[0]] = val;
            n_v         = n_v + 2'd1;
            cnt_v       = sat_inc(cnt_v);
          end
        end
        default: begin
        end
      endcase
    end

    entry_o.n_data     = n_v;
    entry_o.byte0      = b_v[0];
    entry_o.byte1      = b_v[1];
    entry_o.has_end    = last_i;
    entry_o.status     = err_v;
    entry_o.error_pos  = (err_v != ST_OK) ? FIELD_W'(epos_v) : '0;
    entry_o.out_length = (err_v == ST_OK) ? FIELD_W'(cnt_v) : '0;
    push_o             = accept_i && (last_i || n_v != 2'd0);

    // Next state; a finished string restores the reset state
    if (last_i) begin
      mode_d = M_NORMAL;
      hex_d  = '0;
      pos_d  = '0;
      cnt_d  = '0;
      err_d  = ST_OK;
      epos_d = '0;
    end else begin
      mode_d = mode_v;
      hex_d  = (mode_v == M_HEX2 && mode_q != M_HEX2) ? h[3:0] : hex_q;
      pos_d  = sat_inc(pos_q);
      cnt_d  = cnt_v;
      err_d  = err_v;
      epos_d = epos_v;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_NORMAL;
      hex_q  <= '0;
      pos_q  <= '0;
      cnt_q  <= '0;
      err_q  <= ST_OK;
      epos_q <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      hex_q  <= hex_d;
      pos_q  <= pos_d;
      cnt_q  <= cnt_d;
      err_q  <= err_d;
      epos_q <= epos_d;
    end
  end

endmodule

// ===== src/sed_queue.sv =====
// Short FIFO of result bundles between front and back.
module sed_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sed_pkg::sed_entry_t entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output sed_pkg::sed_entry_t head_o
);
  import sed_pkg::*;

  sed_entry_t     mem_q [QDEPTH];
  logic [QAW-1:0] wr_q, wr_d;
  logic [QAW-1:0] rd_q, rd_d;
  logic [QAW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (QAW+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  // Pointer and fill count update
  always_comb begin
    wr_d  = push_i ? wr_q + QAW'(1) : wr_q;
    rd_d  = pop_i ? rd_q + QAW'(1) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (QAW+1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("queue pop while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QAW+1)'(QDEPTH))
    else $error("queue count beyond depth");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == (QAW+1)'(QDEPTH)) |-> (wr_q == rd_q))
    else $error("queue pointers disagree with count");

endmodule

// ===== src/sed_back.sv =====
// Back end: unpacks one queue entry into data and end words.
module sed_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  sed_pkg::sed_entry_t head_i,
  output logic                pop_o,
  sed_out_if.source           out_o
);
  import sed_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic [1:0] total;
  logic       is_data;
  logic       fin;

  // Result index within the head entry
  always_comb begin
    total   = head_i.n_data + {1'b0, head_i.has_end};
    is_data = (idx_q < head_i.n_data);
    fin     = (idx_q == total - 2'd1);
  end

  assign out_o.valid      = !empty_i;
  assign out_o.out_byte   = !is_data ? '0 : (idx_q[0] ? head_i.byte1 : head_i.byte0);
  assign out_o.is_end     = !is_data;
  assign out_o.status     = is_data ? ST_OK : head_i.status;
  assign out_o.error_pos  = is_data ? '0 : head_i.error_pos;
  assign out_o.out_length = is_data ? '0 : head_i.out_length;
  assign out_o.run_last   = fin;

  assign pop_o = out_o.valid && out_o.ready && fin;

  always_comb begin
    idx_d = idx_q;
    if (out_o.valid && out_o.ready) begin
      idx_d = fin ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule
